/* design/bud_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bud_pkg;

    // Size of the destination buffer; the usable capacity is the smaller of
    // this and the buffer_length register.
    localparam int BUFFER_DEPTH = 4096;

    localparam int CAP_W     = 17;
    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int OUT_W     = 48;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RESTART = 3'd1,
        ST_NOMEM   = 3'd2,
        ST_ENDED   = 3'd3,
        ST_BAD     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CODE    = 2'd0,
        REG_END_CODE      = 2'd1,
        REG_ESCAPE_CODE   = 2'd2,
        REG_BUFFER_LENGTH = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_AWAIT  = 5'b00001,
        PH_RAW    = 5'b00010,
        PH_ESC    = 5'b00100,
        PH_ENDED  = 5'b01000,
        PH_FAILED = 5'b10000
    } phase_t;

    // Result beat, highest field first (packed struct lists MSB first).
    typedef struct packed {
        logic [6:0]         pad;
        logic               frame_bad;
        logic               frame_complete;
        logic               waiting_start;
        logic [COUNT_W-1:0] frame_length;
        logic [7:0]         write_byte;
        logic [INDEX_W-1:0] write_index;
        logic               write_valid;
        logic               consumed;
        status_t            status;
    } result_t;

    localparam logic [7:0]         RST_START_CODE    = 8'd161;
    localparam logic [7:0]         RST_END_CODE      = 8'd162;
    localparam logic [7:0]         RST_ESCAPE_CODE   = 8'd163;
    localparam logic [COUNT_W-1:0] RST_BUFFER_LENGTH = 13'd4096;

endpackage

`default_nettype wire

/* design/byte_unstuff_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Byte-unstuffing deframer.
//
// Input channel (s_axis_*): one beat per stuffed byte. s_axis_tuser is the
// mode flag: 0 carries a byte in s_axis_tdata, 1 is a new-frame command that
// clears the length and waits for a start code (tdata ignored).
// Output channel (m_axis_*): exactly one result beat per input beat, in order,
// carrying status, consumed flag, the buffer write (valid, index, byte) and
// the frame flags after the byte.
// Configuration channel (cfg_*): writes start, end and escape codes and the
// buffer length; always ready. Write only while the block is idle.
//
// The result is registered; it appears in the cycle after the beat is accepted.
// Throughput: one beat per cycle while results are taken; the frame state is
// updated in the cycle the beat is accepted, so the next byte sees it
// immediately. The result register is the only stage between the channels.
// Receiver stall: the result holds in the output register and s_axis_tready
// drops until m_axis_tready takes it; nothing is lost or repeated.
// Reset: registers return to their reset codes, the frame waits for a start
// code with zero length, and the output register is empty.
module byte_unstuff_deframer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_byte[7:0]
    input  wire logic [7:0]                      s_axis_tdata,
    // mode
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // status[2:0], consumed[3], write_valid[4], write_index[16:5],
    // write_byte[24:17], frame_length[37:25], waiting_start[38],
    // frame_complete[39], frame_bad[40], zero fill [47:41]
    output logic [bud_pkg::OUT_W-1:0]            m_axis_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bud_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bud_pkg::CFG_DAT_W-1:0]   cfg_data
);

    localparam logic [bud_pkg::CAP_W-1:0] DEPTH_C = bud_pkg::CAP_W'(bud_pkg::BUFFER_DEPTH);

    logic [7:0]                     start_code_reg;
    logic [7:0]                     end_code_reg;
    logic [7:0]                     escape_code_reg;
    logic [bud_pkg::COUNT_W-1:0]    buffer_length_reg;

    bud_pkg::phase_t                phase_reg, phase_next;
    logic [bud_pkg::COUNT_W-1:0]    count_reg, count_next;

    bud_pkg::result_t               result_reg, result_next;
    logic                           out_valid_reg;

    logic                           in_fire;
    logic [bud_pkg::CAP_W-1:0]      capacity;
    logic                           full;
    logic [7:0]                     inv_byte;
    logic                           inv_special;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    // Capacity is the smaller of the register and the physical depth.
    always_comb
    begin
        if (bud_pkg::CAP_W'(buffer_length_reg) > DEPTH_C)
        begin
            capacity = DEPTH_C;
        end
        else
        begin
            capacity = bud_pkg::CAP_W'(buffer_length_reg);
        end
    end

    assign full        = bud_pkg::CAP_W'(count_reg) >= capacity;
    assign inv_byte    = ~s_axis_tdata;
    assign inv_special = (inv_byte == start_code_reg) || (inv_byte == end_code_reg)
                         || (inv_byte == escape_code_reg);

    // Decode one byte against the current frame state.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        result_next = '0;
        result_next.status = bud_pkg::ST_OK;

        if (s_axis_tuser)
        begin
            count_next = '0;
            phase_next = bud_pkg::PH_AWAIT;
        end
        else
        begin
            case (phase_reg)
                bud_pkg::PH_AWAIT:
                begin
                    count_next = '0;
                    phase_next = (s_axis_tdata == start_code_reg) ? bud_pkg::PH_RAW
                                                                  : bud_pkg::PH_FAILED;
                    result_next.consumed = 1'b1;
                end
                bud_pkg::PH_RAW, bud_pkg::PH_ESC:
                begin
                    if (s_axis_tdata == start_code_reg)
                    begin
                        // restart the frame from zero length
                        count_next = '0;
                        phase_next = bud_pkg::PH_RAW;
                        result_next.status   = bud_pkg::ST_RESTART;
                        result_next.consumed = 1'b1;
                    end
                    else if (phase_reg == bud_pkg::PH_RAW && s_axis_tdata == end_code_reg)
                    begin
                        // an empty frame fails on its end code
                        phase_next = (count_reg == '0) ? bud_pkg::PH_FAILED
                                                       : bud_pkg::PH_ENDED;
                        result_next.consumed = 1'b1;
                    end
                    else if (phase_reg == bud_pkg::PH_RAW
                             && s_axis_tdata == escape_code_reg)
                    begin
                        phase_next = bud_pkg::PH_ESC;
                        result_next.consumed = 1'b1;
                    end
                    else if (phase_reg == bud_pkg::PH_ESC
                             && (s_axis_tdata == end_code_reg
                                 || s_axis_tdata == escape_code_reg))
                    begin
                        phase_next = bud_pkg::PH_FAILED;
                        result_next.consumed = 1'b1;
                    end
                    else if (full)
                    begin
                        // refuse the byte, hold the state
                        result_next.status = bud_pkg::ST_NOMEM;
                    end
                    else if (phase_reg == bud_pkg::PH_RAW)
                    begin
                        result_next.write_valid = 1'b1;
                        result_next.write_index = count_reg[bud_pkg::INDEX_W-1:0];
                        result_next.write_byte  = s_axis_tdata;
                        result_next.consumed    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else if (inv_special)
                    begin
                        result_next.write_valid = 1'b1;
                        result_next.write_index = count_reg[bud_pkg::INDEX_W-1:0];
                        result_next.write_byte  = inv_byte;
                        result_next.consumed    = 1'b1;
                        count_next = count_reg + 1'b1;
                        phase_next = bud_pkg::PH_RAW;
                    end
                    else
                    begin
                        phase_next = bud_pkg::PH_FAILED;
                        result_next.consumed = 1'b1;
                    end
                end
                default:
                begin
                    // ended or failed: refuse, hold the state
                end
            endcase
        end

        if (result_next.status == bud_pkg::ST_OK)
        begin
            if (phase_next == bud_pkg::PH_ENDED)
            begin
                result_next.status = bud_pkg::ST_ENDED;
            end
            else if (phase_next == bud_pkg::PH_FAILED)
            begin
                result_next.status = bud_pkg::ST_BAD;
            end
        end

        result_next.frame_length   = count_next;
        result_next.waiting_start  = (phase_next == bud_pkg::PH_AWAIT);
        result_next.frame_complete = (phase_next == bud_pkg::PH_ENDED);
        result_next.frame_bad      = (phase_next == bud_pkg::PH_FAILED);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg    <= bud_pkg::RST_START_CODE;
            end_code_reg      <= bud_pkg::RST_END_CODE;
            escape_code_reg   <= bud_pkg::RST_ESCAPE_CODE;
            buffer_length_reg <= bud_pkg::RST_BUFFER_LENGTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bud_pkg::REG_START_CODE:    start_code_reg    <= cfg_data[7:0];
                bud_pkg::REG_END_CODE:      end_code_reg      <= cfg_data[7:0];
                bud_pkg::REG_ESCAPE_CODE:   escape_code_reg   <= cfg_data[7:0];
                bud_pkg::REG_BUFFER_LENGTH: buffer_length_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Frame state: advance on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bud_pkg::PH_AWAIT;
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Output register: load on accept, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

/* sim/deframe_checker.sv */
`timescale 1ns / 1ps

// Watches the deframer channels, predicts every result beat from the input
// beats and the register writes, and compares the results in order.
module deframe_checker
    import bud_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,
    input  wire logic                 s_axis_tuser,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [OUT_W-1:0]     m_axis_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        pending
);

    logic [7:0]         start_code;
    logic [7:0]         end_code;
    logic [7:0]         escape_code;
    logic [COUNT_W-1:0] buf_len;
    phase_t             frame_phase;
    logic [COUNT_W-1:0] payload_cnt;
    result_t            expected_results[$];

    // Advance the frame state by one beat and build the result it causes.
    task automatic deframe_step(input logic mode, input logic [7:0] b, output result_t r);
        logic [7:0] inv;
        int         cap;
        inv = ~b;
        cap = (buf_len > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(buf_len);
        r = '0;
        if (mode)
        begin
            payload_cnt = '0;
            frame_phase = PH_AWAIT;
        end
        else if (frame_phase == PH_AWAIT)
        begin
            payload_cnt = '0;
            frame_phase = (b == start_code) ? PH_RAW : PH_FAILED;
            r.consumed = 1'b1;
        end
        else if (frame_phase == PH_RAW || frame_phase == PH_ESC)
        begin
            if (b == start_code)
            begin
                payload_cnt = '0;
                frame_phase = PH_RAW;
                r.status = ST_RESTART;
                r.consumed = 1'b1;
            end
            else if (frame_phase == PH_RAW && b == end_code)
            begin
                frame_phase = (payload_cnt == 0) ? PH_FAILED : PH_ENDED;
                r.consumed = 1'b1;
            end
            else if (frame_phase == PH_RAW && b == escape_code)
            begin
                frame_phase = PH_ESC;
                r.consumed = 1'b1;
            end
            else if (frame_phase == PH_ESC && (b == end_code || b == escape_code))
            begin
                frame_phase = PH_FAILED;
                r.consumed = 1'b1;
            end
            else if (int'(payload_cnt) >= cap)
            begin
                r.status = ST_NOMEM;
            end
            else if (frame_phase == PH_RAW)
            begin
                r.write_valid = 1'b1;
                r.write_index = payload_cnt[INDEX_W-1:0];
                r.write_byte = b;
                payload_cnt = payload_cnt + 1'b1;
                r.consumed = 1'b1;
            end
            else if (inv == start_code || inv == end_code || inv == escape_code)
            begin
                r.write_valid = 1'b1;
                r.write_index = payload_cnt[INDEX_W-1:0];
                r.write_byte = inv;
                payload_cnt = payload_cnt + 1'b1;
                frame_phase = PH_RAW;
                r.consumed = 1'b1;
            end
            else
            begin
                frame_phase = PH_FAILED;
                r.consumed = 1'b1;
            end
        end

        if (r.status == ST_OK)
        begin
            if (frame_phase == PH_ENDED)
                r.status = ST_ENDED;
            else if (frame_phase == PH_FAILED)
                r.status = ST_BAD;
        end
        r.frame_length = payload_cnt;
        r.waiting_start = (frame_phase == PH_AWAIT);
        r.frame_complete = (frame_phase == PH_ENDED);
        r.frame_bad = (frame_phase == PH_FAILED);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        result_t pred;
        if (!rst_n)
        begin
            start_code = RST_START_CODE;
            end_code = RST_END_CODE;
            escape_code = RST_ESCAPE_CODE;
            buf_len = RST_BUFFER_LENGTH;
            frame_phase = PH_AWAIT;
            payload_cnt = '0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_CODE:    start_code = cfg_data[7:0];
                    REG_END_CODE:      end_code = cfg_data[7:0];
                    REG_ESCAPE_CODE:   escape_code = cfg_data[7:0];
                    REG_BUFFER_LENGTH: buf_len = cfg_data;
                    default: ;
                endcase
            end

            // Results are registered before they leave, so compare before
            // queueing the beat taken at this same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no input pending: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("consumed", 16'(want.consumed), 16'(got.consumed));
                    check_field("write_valid", 16'(want.write_valid), 16'(got.write_valid));
                    check_field("write_index", 16'(want.write_index), 16'(got.write_index));
                    check_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
                    check_field("frame_length", 16'(want.frame_length),
                                16'(got.frame_length));
                    check_field("waiting_start", 16'(want.waiting_start),
                                16'(got.waiting_start));
                    check_field("frame_complete", 16'(want.frame_complete),
                                16'(got.frame_complete));
                    check_field("frame_bad", 16'(want.frame_bad), 16'(got.frame_bad));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_step(s_axis_tuser, s_axis_tdata, pred);
                expected_results.push_back(pred);
            end
        end
        pending = expected_results.size();
    end

endmodule

/* sim/byte_unstuff_deframer_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the deframer. The checker beside the block does
// all prediction and comparison; this module only drives beats and decides
// when the run is over.
module byte_unstuff_deframer_tb;
    import bud_pkg::*;

    // Give up after this many cycles without a beat on any channel.
    localparam int IDLE_LIMIT = 2000;

    // Payload bytes in the back-to-back frame under an oversized length.
    localparam int LONG_FRAME = 48;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int fail_count;
    int pending;

    // Current register values, mirrored so frames can be built from them.
    logic [7:0]         start_v;
    logic [7:0]         end_v;
    logic [7:0]         esc_v;
    logic [COUNT_W-1:0] blen_v;

    int   items_sent;
    logic burst;        // hold both sides busy, no idle cycles
    int   idle_cycles;

    byte_unstuff_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    deframe_checker deframe_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Drive one input beat at a falling edge, hold it until the block takes
    // it, then insert a random gap. Returns at a falling edge.
    task automatic send_beat(input logic mode, input logic [7:0] b);
        int gap;
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
        gap = pick_idle();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = 8'($urandom_range(0, 255));
            s_axis_tuser = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop sending and hold until every result has come back.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Write all four registers; the code registers get junk in the unused
    // upper bits, which the block must drop.
    task automatic set_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                             input logic [COUNT_W-1:0] len);
        start_v = s;
        end_v = e;
        esc_v = x;
        blen_v = len;
        write_reg(REG_START_CODE, {5'($urandom_range(0, 31)), s});
        write_reg(REG_END_CODE, {5'($urandom_range(0, 31)), e});
        write_reg(REG_ESCAPE_CODE, {5'($urandom_range(0, 31)), x});
        write_reg(REG_BUFFER_LENGTH, len);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        int         tries;
        tries = 0;
        do
        begin
            b = 8'($urandom_range(0, 255));
            tries++;
        end
        while ((b == start_v || b == end_v || b == esc_v) && tries < 50);
        return b;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 2))
            0: return start_v;
            1: return end_v;
            default: return esc_v;
        endcase
    endfunction

    task automatic send_escaped();
        send_beat(1'b0, esc_v);
        send_beat(1'b0, ~pick_code());
    endtask

    // A broken piece of a frame: stray bytes, bad escapes, early codes.
    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_beat(1'b0, 8'($urandom_range(0, 255)));
            1:
            begin
                send_beat(1'b0, esc_v);
                send_beat(1'b0, 8'($urandom_range(0, 255)));
            end
            2: send_beat(1'b0, start_v);
            3: send_beat(1'b0, end_v);
            4: send_beat(1'b1, 8'($urandom_range(0, 255)));
            default:
            begin
                send_beat(1'b0, esc_v);
                send_beat(1'b0, ($urandom_range(0, 1) != 0) ? esc_v : end_v);
            end
        endcase
    endtask

    // One mostly well-formed frame with random content.
    task automatic send_frame();
        int len;
        int r;
        burst = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 5)
            len = 0;
        else if (r < 85)
            len = $urandom_range(1, 10);
        else
            len = $urandom_range(11, 40);
        if ($urandom_range(0, 9) != 0)
            send_beat(1'b1, 8'($urandom_range(0, 255)));
        send_beat(1'b0, start_v);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_noise();
            else if ($urandom_range(0, 4) == 0)
                send_escaped();
            else
                send_beat(1'b0, plain_byte());
        end
        if ($urandom_range(0, 9) != 0)
            send_beat(1'b0, end_v);
        // A byte after the frame has closed must be refused.
        if ($urandom_range(0, 7) == 0)
            send_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_frames(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            send_frame();
            if ($urandom_range(0, 59) == 0)
                drain();
        end
    endtask

    // Receiver: ready in runs, stalled in random gaps.
    initial
    begin : receiver
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            stall = pick_idle();
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Watchdog: count cycles with no beat on any channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        burst = 1'b0;
        start_v = RST_START_CODE;
        end_v = RST_END_CODE;
        esc_v = RST_ESCAPE_CODE;
        blen_v = RST_BUFFER_LENGTH;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: reset codes, every path of the frame state.
        send_beat(1'b0, 8'h00);           // not a start code while waiting: fail
        send_beat(1'b0, 8'hFF);           // refused after failure
        send_beat(1'b1, 8'hFF);           // new frame
        send_beat(1'b0, start_v);
        send_beat(1'b0, end_v);           // end on an empty frame: fail
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, start_v);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, esc_v);
        send_beat(1'b0, ~start_v);
        send_beat(1'b0, esc_v);
        send_beat(1'b0, ~end_v);
        send_beat(1'b0, esc_v);
        send_beat(1'b0, ~esc_v);
        send_beat(1'b0, start_v);         // restart inside a frame
        send_beat(1'b0, 8'h55);
        send_beat(1'b0, esc_v);
        send_beat(1'b0, start_v);         // restart right after an escape
        send_beat(1'b0, esc_v);
        send_beat(1'b0, end_v);           // end after escape: fail
        send_beat(1'b1, 8'h5A);
        send_beat(1'b0, start_v);
        send_beat(1'b0, 8'h01);
        send_beat(1'b0, end_v);           // frame ended
        send_beat(1'b0, 8'h33);           // refused after end
        send_beat(1'b1, 8'hA5);
        send_beat(1'b0, start_v);
        send_beat(1'b0, esc_v);
        send_beat(1'b0, 8'h12);           // not an inverted code: fail
        random_frames(220);
        drain();

        // One-byte buffer: the second payload byte, raw or escaped, is refused.
        set_codes(8'h00, 8'hFF, 8'h55, 13'd1);
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, start_v);
        send_beat(1'b0, 8'h37);
        send_beat(1'b0, 8'h38);
        send_beat(1'b0, esc_v);
        send_beat(1'b0, ~esc_v);
        send_beat(1'b0, end_v);
        random_frames(220);
        drain();

        // Zero-length buffer refuses every payload byte.
        set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 13'd0);
        random_frames(150);
        drain();

        // All three codes equal: start wins, then end, then escape.
        set_codes(8'h42, 8'h42, 8'h42, 13'd4096);
        random_frames(200);
        drain();

        // Length beyond the buffer depth is clipped to it; run one long
        // frame back to back under that length.
        set_codes(8'h7E, 8'h7D, 8'h7C, 13'h1FFF);
        burst = 1'b1;
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, start_v);
        for (int i = 0; i < LONG_FRAME; i++)
            send_beat(1'b0, plain_byte());
        send_beat(1'b0, end_v);
        random_frames(150);
        drain();

        // Random codes with small buffers, where the limit is reached often.
        repeat (3)
        begin
            set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 13'($urandom_range(1, 24)));
            random_frames(170);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
